// File: rtl/pimd_pkg.sv
package pimd_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_TAG,
        PH_VALUE,
        PH_LENGTH,
        PH_SKIP
    } phase_t;

    // Wire types that the parser acts on
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // Byte counts skipped for fixed-size wire types
    localparam int SKIP_FIXED64 = 8;
    localparam int SKIP_FIXED32 = 4;

    // Field numbers of the held record
    localparam logic [31:0] FLD_MOUSE_X  = 32'd1;
    localparam logic [31:0] FLD_MOUSE_Y  = 32'd2;
    localparam logic [31:0] FLD_WHEEL    = 32'd3;
    localparam logic [31:0] FLD_LEFT     = 32'd4;
    localparam logic [31:0] FLD_RIGHT    = 32'd5;
    localparam logic [31:0] FLD_KEYS     = 32'd6;
    localparam logic [31:0] FLD_MIDDLE   = 32'd7;

    // Varint geometry
    localparam int VARINT_BITS   = 64;
    localparam int VARINT_DIGIT  = 7;
    localparam int BITPOS_W      = 7;

    // Classified payload byte, as queued between front and back
    typedef struct packed {
        logic [6:0] bits;   // varint data bits
        logic       cont;   // continuation flag
        logic       last;   // final byte of the payload
    } item_t;

endpackage

// File: rtl/pimd_in_if.sv
interface pimd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

// File: rtl/pimd_out_if.sv
interface pimd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mouse_x;
    logic signed [31:0] mouse_y;
    logic signed [31:0] mouse_wheel;
    logic [7:0]         left_button;
    logic [7:0]         right_button;
    logic [31:0]        key_bits;
    logic [7:0]         middle_button;
    logic               cut_short;

    modport source (
        output valid, output mouse_x, output mouse_y, output mouse_wheel,
        output left_button, output right_button, output key_bits,
        output middle_button, output cut_short, input ready
    );
    modport sink (
        input valid, input mouse_x, input mouse_y, input mouse_wheel,
        input left_button, input right_button, input key_bits,
        input middle_button, input cut_short, output ready
    );
endinterface

// File: rtl/pimd_front.sv
module pimd_front (
    input  logic               clk,
    input  logic               rst_n,
    pimd_in_if.sink            payload,
    output logic               item_valid,
    output pimd_pkg::item_t    item,
    input  logic               item_ready
);

    logic            valid_reg;
    logic            valid_next;
    pimd_pkg::item_t item_reg;
    logic            take;

    // Stage accepts whenever it is empty or drains this cycle
    assign payload.ready = !valid_reg || item_ready;
    assign take          = payload.valid && payload.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Split the byte into data bits and continuation flag
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.bits <= payload.payload_byte[6:0];
            item_reg.cont <= payload.payload_byte[7];
            item_reg.last <= payload.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/pimd_queue.sv
module pimd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    input  pimd_pkg::item_t    wr_item,
    output logic               wr_ready,
    output logic               rd_valid,
    output pimd_pkg::item_t    rd_item,
    input  logic               rd_ready
);

    // Two-entry queue
    pimd_pkg::item_t mem [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/pimd_back.sv
module pimd_back #(
    parameter int SKIP_LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  pimd_pkg::item_t    item,
    output logic               item_ready,
    pimd_out_if.source         record
);

    localparam int AW = pimd_pkg::VARINT_BITS;
    localparam int BW = pimd_pkg::BITPOS_W;
    localparam int SW = SKIP_LENGTH_BITS;

    pimd_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [BW-1:0]    bitpos_reg, bitpos_next;
    logic [31:0]      field_reg, field_next;
    logic [SW-1:0]    skip_reg, skip_next;

    logic [31:0]      mouse_x_reg, mouse_x_next;
    logic [31:0]      mouse_y_reg, mouse_y_next;
    logic [31:0]      wheel_reg, wheel_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       right_reg, right_next;
    logic [7:0]       middle_reg, middle_next;
    logic [31:0]      keys_reg, keys_next;

    logic             out_valid_reg;
    logic             take;
    logic             in_range;
    logic [AW-1:0]    acc_upd;
    logic [BW-1:0]    bitpos_upd;
    logic [SW-1:0]    skip_dec;
    logic             cut;

    // A last byte needs a free output register; others always go through
    assign item_ready = !item.last || !out_valid_reg || record.ready;
    assign take       = item_valid && item_ready;

    // Varint digit merge; digits past bit 63 are dropped
    assign in_range   = !bitpos_reg[BW-1];
    assign acc_upd    = in_range
                        ? (acc_reg | (AW'(item.bits) << bitpos_reg[BW-2:0]))
                        : acc_reg;
    assign bitpos_upd = in_range ? (bitpos_reg + BW'(pimd_pkg::VARINT_DIGIT)) : bitpos_reg;
    assign skip_dec   = (skip_reg != '0) ? (skip_reg - SW'(1)) : skip_reg;

    // Parser next state
    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        bitpos_next  = bitpos_reg;
        field_next   = field_reg;
        skip_next    = skip_reg;
        mouse_x_next = mouse_x_reg;
        mouse_y_next = mouse_y_reg;
        wheel_next   = wheel_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        middle_next  = middle_reg;
        keys_next    = keys_reg;
        cut          = 1'b0;

        if (phase_reg == pimd_pkg::PH_SKIP)
        begin
            skip_next = skip_dec;
            if (skip_dec == '0)
            begin
                phase_next = pimd_pkg::PH_TAG;
            end
        end
        else if (item.cont)
        begin
            acc_next    = acc_upd;
            bitpos_next = bitpos_upd;
        end
        else
        begin
            acc_next    = '0;
            bitpos_next = '0;
            case (phase_reg)
                pimd_pkg::PH_TAG:
                begin
                    field_next = acc_upd[34:3];
                    case (acc_upd[2:0])
                        pimd_pkg::WT_VARINT:  phase_next = pimd_pkg::PH_VALUE;
                        pimd_pkg::WT_FIXED64:
                        begin
                            skip_next  = SW'(pimd_pkg::SKIP_FIXED64);
                            phase_next = pimd_pkg::PH_SKIP;
                        end
                        pimd_pkg::WT_FIXED32:
                        begin
                            skip_next  = SW'(pimd_pkg::SKIP_FIXED32);
                            phase_next = pimd_pkg::PH_SKIP;
                        end
                        pimd_pkg::WT_LEN:     phase_next = pimd_pkg::PH_LENGTH;
                        default:              phase_next = pimd_pkg::PH_TAG;
                    endcase
                end
                pimd_pkg::PH_VALUE:
                begin
                    case (field_reg)
                        pimd_pkg::FLD_MOUSE_X: mouse_x_next = acc_upd[31:0];
                        pimd_pkg::FLD_MOUSE_Y: mouse_y_next = acc_upd[31:0];
                        pimd_pkg::FLD_WHEEL:   wheel_next   = acc_upd[31:0];
                        pimd_pkg::FLD_LEFT:    left_next    = acc_upd[7:0];
                        pimd_pkg::FLD_RIGHT:   right_next   = acc_upd[7:0];
                        pimd_pkg::FLD_KEYS:    keys_next    = acc_upd[31:0];
                        pimd_pkg::FLD_MIDDLE:  middle_next  = acc_upd[7:0];
                        default:               ;
                    endcase
                    phase_next = pimd_pkg::PH_TAG;
                end
                default:
                begin
                    // length varint
                    skip_next  = acc_upd[SW-1:0];
                    phase_next = (acc_upd[SW-1:0] == '0) ? pimd_pkg::PH_TAG
                                                         : pimd_pkg::PH_SKIP;
                end
            endcase
        end

        // End of payload: flag an open field and drop partial state
        if (item.last)
        begin
            cut         = (phase_next != pimd_pkg::PH_TAG) || (bitpos_next != '0);
            phase_next  = pimd_pkg::PH_TAG;
            acc_next    = '0;
            bitpos_next = '0;
            skip_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pimd_pkg::PH_TAG;
            acc_reg       <= '0;
            bitpos_reg    <= '0;
            field_reg     <= '0;
            skip_reg      <= '0;
            mouse_x_reg   <= '0;
            mouse_y_reg   <= '0;
            wheel_reg     <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            middle_reg    <= '0;
            keys_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                bitpos_reg  <= bitpos_next;
                field_reg   <= field_next;
                skip_reg    <= skip_next;
                mouse_x_reg <= mouse_x_next;
                mouse_y_reg <= mouse_y_next;
                wheel_reg   <= wheel_next;
                left_reg    <= left_next;
                right_reg   <= right_next;
                middle_reg  <= middle_next;
                keys_reg    <= keys_next;
            end
            if (take && item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (record.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output record register
    always_ff @(posedge clk)
    begin
        if (take && item.last)
        begin
            record.mouse_x       <= mouse_x_next;
            record.mouse_y       <= mouse_y_next;
            record.mouse_wheel   <= wheel_next;
            record.left_button   <= left_next;
            record.right_button  <= right_next;
            record.key_bits      <= keys_next;
            record.middle_button <= middle_next;
            record.cut_short     <= cut;
        end
    end

    assign record.valid = out_valid_reg;

endmodule

// File: rtl/protobuf_input_message_decoder.sv
// Path: a final payload byte's record passes the input stage, the 2-entry queue
// and the parser with its output register before it shows.
// Throughput: 1 byte per cycle; the parser consumes one queued byte each cycle,
// and only a final byte waits for the output register to be free.
// Reset: rst_n asynchronous, active low; parser returns to tag phase, held fields clear.
module protobuf_input_message_decoder #(
    parameter int SKIP_LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    pimd_in_if.sink     payload,
    pimd_out_if.source  record
);

    logic            f_valid;
    pimd_pkg::item_t f_item;
    logic            f_ready;
    logic            q_valid;
    pimd_pkg::item_t q_item;
    logic            q_ready;

    pimd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .item_valid (f_valid),
        .item       (f_item),
        .item_ready (f_ready)
    );

    pimd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_item  (f_item),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .rd_ready (q_ready)
    );

    pimd_back #(
        .SKIP_LENGTH_BITS (SKIP_LENGTH_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_item),
        .item_ready (q_ready),
        .record     (record)
    );

endmodule

// File: rtl/pimd_checker.sv
module pimd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_mouse_x,
    input  logic        out_cut_short
);

    // A pending record stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("record dropped while stalled");

    // A stalled record keeps its word
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_mouse_x) && $stable(out_cut_short))
        else $error("record changed while stalled");

    // Pipeline is empty out of reset: no record right after reset is released
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid ##1 !out_valid)
        else $error("record right after reset");

    // Input side is open out of reset
    a_reset_ready: assert property (@(posedge clk)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");

endmodule

bind protobuf_input_message_decoder pimd_checker u_pimd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (payload.ready),
    .out_valid     (record.valid),
    .out_ready     (record.ready),
    .out_mouse_x   (record.mouse_x),
    .out_cut_short (record.cut_short)
);
